FILE: rtl/pts_pkg.sv
// Package for the priority task scheduler.
// Request and status codes, controller states and the queue command struct.
// No dependencies.
package pts_pkg;

   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0,
      REQ_TICK   = 3'd1,
      REQ_SLEEP  = 3'd2,
      REQ_EXIT   = 3'd3,
      REQ_SWITCH = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD     = 2'd2,
      ST_NO_TASK = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WAKE,
      S_POP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

   localparam logic [15:0] MIN_STACK = 16'd32;

endpackage

FILE: rtl/pts_req_if.sv
// Request channel of the priority task scheduler.
// Depends on nothing.
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  task_priority;
   logic [15:0] stack_size;
   logic [31:0] sleep_ticks;

   modport source (output valid, req_type, task_priority, stack_size, sleep_ticks,
                   input ready);
   modport sink (input valid, req_type, task_priority, stack_size, sleep_ticks,
                 output ready);
endinterface

FILE: rtl/pts_rsp_if.sv
// Response channel of the priority task scheduler.
// Depends on nothing.
interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  new_task_id;
   logic        running_valid;
   logic [3:0]  running_id;
   logic        switch_request;
   logic [31:0] tick_now;

   modport source (output valid, status, new_task_id, running_valid, running_id,
                   switch_request, tick_now, input ready);
   modport sink (input valid, status, new_task_id, running_valid, running_id,
                 switch_request, tick_now, output ready);
endinterface

FILE: rtl/pts_cell.sv
// One slot of a sorted queue: holds key and data, takes from a neighbour.
// Depends on pts_pkg.
module pts_cell #(
   parameter int KEY_W  = 8,
   parameter int DATA_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::queue_cmd_type cmd,
   input  logic [KEY_W-1:0]      new_key,
   input  logic [DATA_W-1:0]     new_data,
   input  logic                  left_valid,
   input  logic [KEY_W-1:0]      left_key,
   input  logic [DATA_W-1:0]     left_data,
   input  logic                  left_after,
   input  logic                  right_valid,
   input  logic [KEY_W-1:0]      right_key,
   input  logic [DATA_W-1:0]     right_data,
   output logic                  valid,
   output logic [KEY_W-1:0]      key,
   output logic [DATA_W-1:0]     data,
   output logic                  after
);
   import pts_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // new entry goes behind every entry with key <= its own
   assign after = valid_ff && (key_ff <= new_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (cmd.push) begin
         if (!after) begin
            if (left_after) begin
               valid_in = 1'b1;
               key_in   = new_key;
               data_in  = new_data;
            end else begin
               valid_in = left_valid;
               key_in   = left_key;
               data_in  = left_data;
            end
         end
      end else if (cmd.pop) begin
         valid_in = right_valid;
         key_in   = right_key;
         data_in  = right_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign data  = data_ff;
endmodule

FILE: rtl/pts_queue.sv
// Sorted queue built as a row of pts_cell slots, head at slot 0.
// Depends on pts_pkg and pts_cell.
module pts_queue #(
   parameter int DEPTH  = 16,
   parameter int KEY_W  = 8,
   parameter int DATA_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pts_pkg::queue_cmd_type cmd,
   input  logic [KEY_W-1:0]       new_key,
   input  logic [DATA_W-1:0]      new_data,
   output logic                   head_valid,
   output logic [KEY_W-1:0]       head_key,
   output logic [DATA_W-1:0]      head_data
);
   import pts_pkg::*;

   logic              vld [DEPTH];
   logic [KEY_W-1:0]  keys [DEPTH];
   logic [DATA_W-1:0] dats [DEPTH];
   logic              aft [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              lv, la, rv;
      logic [KEY_W-1:0]  lk, rk;
      logic [DATA_W-1:0] ld, rd;
      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign la = 1'b1;
         assign lk = '0;
         assign ld = '0;
      end else begin : g_mid
         assign lv = vld[i-1];
         assign la = aft[i-1];
         assign lk = keys[i-1];
         assign ld = dats[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign rv = 1'b0;
         assign rk = '0;
         assign rd = '0;
      end else begin : g_inner
         assign rv = vld[i+1];
         assign rk = keys[i+1];
         assign rd = dats[i+1];
      end
      pts_cell #(.KEY_W(KEY_W), .DATA_W(DATA_W)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .new_key(new_key), .new_data(new_data),
         .left_valid(lv), .left_key(lk), .left_data(ld), .left_after(la),
         .right_valid(rv), .right_key(rk), .right_data(rd),
         .valid(vld[i]), .key(keys[i]), .data(dats[i]), .after(aft[i])
      );
   end

   assign head_valid = vld[0];
   assign head_key   = keys[0];
   assign head_data  = dats[0];
endmodule

FILE: rtl/priority_task_scheduler.sv
// Top level of the priority task scheduler.
// Depends on pts_pkg, pts_req_if, pts_rsp_if and pts_queue.
//
// One request is handled at a time and gives one response. Create, sleep, exit
// and bad codes go from S_IDLE through S_DONE to the response register; switch
// passes S_POP and a tick the S_WAKE loop before S_DONE. The wake loop moves one
// sleeper a cycle from the head of the sleep queue into the ready queue. Both
// queues are rows of sorted slots that insert or pop in a single registered step.
module priority_task_scheduler #(
   parameter int MAX_TASKS  = 16,
   parameter int TICK_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan
);
   import pts_pkg::*;

   localparam int ID_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   state_type             state_ff, state_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [CNT_W-1:0]      created_ff, created_in;
   logic                  live_ff, live_in;
   logic [ID_W-1:0]       run_id_ff, run_id_in;
   logic [7:0]            run_prio_ff, run_prio_in;
   logic [1:0]            status_ff, status_in;
   logic [ID_W-1:0]       new_id_ff, new_id_in;
   logic                  sw_ff, sw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            o_status_ff, o_status_in;
   logic [3:0]            o_new_id_ff, o_new_id_in;
   logic                  o_run_valid_ff, o_run_valid_in;
   logic [3:0]            o_run_id_ff, o_run_id_in;
   logic                  o_sw_ff, o_sw_in;
   logic [31:0]           o_tick_ff, o_tick_in;

   queue_cmd_type         rdy_cmd, slp_cmd;
   logic [7:0]            rdy_key;
   logic [ID_W-1:0]       rdy_data;
   logic                  rdy_hv;
   logic [7:0]            rdy_hk;
   logic [ID_W-1:0]       rdy_hd;
   logic [TICK_WIDTH-1:0] slp_key;
   logic [ID_W+7:0]       slp_data;
   logic                  slp_hv;
   logic [TICK_WIDTH-1:0] slp_hk;
   logic [ID_W+7:0]       slp_hd;

   pts_queue #(.DEPTH(MAX_TASKS), .KEY_W(8), .DATA_W(ID_W)) u_ready (
      .clock(clock), .reset(reset), .cmd(rdy_cmd), .new_key(rdy_key),
      .new_data(rdy_data), .head_valid(rdy_hv), .head_key(rdy_hk), .head_data(rdy_hd)
   );

   pts_queue #(.DEPTH(MAX_TASKS), .KEY_W(TICK_WIDTH), .DATA_W(ID_W + 8)) u_sleep (
      .clock(clock), .reset(reset), .cmd(slp_cmd), .new_key(slp_key),
      .new_data(slp_data), .head_valid(slp_hv), .head_key(slp_hk), .head_data(slp_hd)
   );

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      created_in     = created_ff;
      live_in        = live_ff;
      run_id_in      = run_id_ff;
      run_prio_in    = run_prio_ff;
      status_in      = status_ff;
      new_id_in      = new_id_ff;
      sw_in          = sw_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      o_status_in    = o_status_ff;
      o_new_id_in    = o_new_id_ff;
      o_run_valid_in = o_run_valid_ff;
      o_run_id_in    = o_run_id_ff;
      o_sw_in        = o_sw_ff;
      o_tick_in      = o_tick_ff;
      rdy_cmd        = '0;
      slp_cmd        = '0;
      rdy_key        = run_prio_ff;
      rdy_data       = run_id_ff;
      slp_key        = tick_ff + TICK_WIDTH'(req_chan.sleep_ticks);
      slp_data       = {run_prio_ff, run_id_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               status_in = ST_OK;
               new_id_in = '0;
               sw_in     = 1'b0;
               state_in  = S_DONE;
               unique case (req_chan.req_type)
                  REQ_CREATE: begin
                     if (req_chan.stack_size < MIN_STACK) begin
                        status_in = ST_BAD;
                     end else if (created_ff >= CNT_W'(MAX_TASKS)) begin
                        status_in = ST_FULL;
                     end else begin
                        rdy_cmd.push = 1'b1;
                        rdy_key      = req_chan.task_priority;
                        rdy_data     = ID_W'(created_ff);
                        new_id_in    = ID_W'(created_ff);
                        created_in   = created_ff + CNT_W'(1);
                     end
                  end
                  REQ_TICK: begin
                     tick_in  = tick_ff + TICK_WIDTH'(1);
                     state_in = S_WAKE;
                  end
                  REQ_SLEEP: begin
                     if (!live_ff) begin
                        status_in = ST_NO_TASK;
                     end else begin
                        slp_cmd.push = 1'b1;
                        live_in      = 1'b0;
                        sw_in        = 1'b1;
                     end
                  end
                  REQ_EXIT: begin
                     if (!live_ff) begin
                        status_in = ST_NO_TASK;
                     end else begin
                        live_in = 1'b0;
                        sw_in   = 1'b1;
                     end
                  end
                  REQ_SWITCH: begin
                     if (live_ff) begin
                        rdy_cmd.push = 1'b1;
                        live_in      = 1'b0;
                     end
                     state_in = S_POP;
                  end
                  default: begin
                     status_in = ST_BAD;
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (slp_hv && (slp_hk <= tick_ff)) begin
               slp_cmd.pop  = 1'b1;
               rdy_cmd.push = 1'b1;
               rdy_key      = slp_hd[ID_W +: 8];
               rdy_data     = slp_hd[ID_W-1:0];
            end else begin
               sw_in    = rdy_hv && live_ff && (rdy_hk < run_prio_ff);
               state_in = S_DONE;
            end
         end
         S_POP: begin
            if (rdy_hv) begin
               rdy_cmd.pop = 1'b1;
               live_in     = 1'b1;
               run_id_in   = rdy_hd;
               run_prio_in = rdy_hk;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               o_status_in    = status_ff;
               o_new_id_in    = 4'(new_id_ff);
               o_run_valid_in = live_ff;
               o_run_id_in    = live_ff ? 4'(run_id_ff) : 4'd0;
               o_sw_in        = sw_ff;
               o_tick_in      = 32'(tick_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         created_ff   <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         created_ff   <= created_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_id_ff      <= run_id_in;
      run_prio_ff    <= run_prio_in;
      status_ff      <= status_in;
      new_id_ff      <= new_id_in;
      sw_ff          <= sw_in;
      o_status_ff    <= o_status_in;
      o_new_id_ff    <= o_new_id_in;
      o_run_valid_ff <= o_run_valid_in;
      o_run_id_ff    <= o_run_id_in;
      o_sw_ff        <= o_sw_in;
      o_tick_ff      <= o_tick_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = o_status_ff;
   assign rsp_chan.new_task_id    = o_new_id_ff;
   assign rsp_chan.running_valid  = o_run_valid_ff;
   assign rsp_chan.running_id     = o_run_id_ff;
   assign rsp_chan.switch_request = o_sw_ff;
   assign rsp_chan.tick_now       = o_tick_ff;

   a_idle_id : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.running_valid |-> rsp_chan.running_id == 4'd0)
      else $error("running id set with no running task");

   a_sw_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.switch_request |-> rsp_chan.status == ST_OK)
      else $error("switch request on failed request");

   a_id_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.new_task_id != 4'd0 |-> rsp_chan.status == ST_OK)
      else $error("task id on failed request");

   a_wake_tick : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAKE |=> tick_ff == $past(tick_ff))
      else $error("tick moved during wake loop");
endmodule
